/* src/wdsm_pkg.sv */
// Shared types, widths and codes of the weighted drift stability monitor.
package wdsm_pkg;

  localparam int METRIC_W   = 32;
  localparam int IN_W       = 5 * METRIC_W;
  localparam int UNIT_W     = 17;
  localparam int OUT_W      = 136;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int WEIGHT_W   = 24;
  localparam int LIMIT_W    = 31;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_W_COHERENCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_W_SPECTRAL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_W_MEMORY      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COST_GAIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_JOINT_LIMIT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FC_THRESHOLD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STEADY_MARGIN = 3'd7;

  typedef enum logic [2:0] {
    MUL_W0,
    MUL_W1,
    MUL_W2,
    MUL_GAIN,
    MUL_LEAK
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_clr;
    logic     acc_en;
    logic     level_en;
    logic     change_en;
    logic     mag_en;
    logic     joint_en;
    logic     cost_en;
    logic     fc_en;
    logic     div_start;
    logic     div_sel;
    logic     steady_en;
    logic     agree_en;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } sts_t;

endpackage

/* src/wdsm_div.sv */
// Serial restoring divider forming clamp(1 - num / lim, 0, 1), one quotient bit a cycle.
module wdsm_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [32:0]         num_i,
  input  logic [30:0]         lim_i,
  output logic                busy_o,
  output logic [FRAC_BITS:0]  res_o
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [30:0] ONE = 31'(1) << FRAC_BITS;

  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [30:0]          rem_q, rem_d;
  logic [30:0]          lim_q, lim_d;
  logic [FRAC_BITS-1:0] quo_q, quo_d;
  logic                 ge_q, ge_d;
  logic [30:0]          lim_eff;
  logic [31:0]          rem2;
  logic                 fits;

  always_comb begin
    lim_eff = (lim_i == '0) ? ONE : lim_i;
    rem2    = {rem_q, 1'b0};
    fits    = rem2 >= {1'b0, lim_q};
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    lim_d   = lim_q;
    quo_d   = quo_q;
    ge_d    = ge_q;
    if (start_i) begin
      cnt_d = CNT_W'(FRAC_BITS);
      lim_d = lim_eff;
      ge_d  = num_i >= {2'b00, lim_eff};
      rem_d = num_i[30:0];
      quo_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = fits ? 31'(rem2 - {1'b0, lim_q}) : rem2[30:0];
      quo_d = {quo_q[FRAC_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lim_q <= lim_d;
    quo_q <= quo_d;
    ge_q  <= ge_d;
  end

  assign busy_o = cnt_q != '0;
  // Quotient of one or more clamps to zero
  assign res_o  = ge_q ? '0 : ((FRAC_BITS + 1)'(1) << FRAC_BITS) - {1'b0, quo_q};

endmodule

/* src/wdsm_dp.sv */
// Datapath: configuration registers, shared multiplier, level and change, divider, result register.
module wdsm_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [wdsm_pkg::IN_W-1:0]       in_data_i,
  input  logic                            cfg_we_i,
  input  logic [wdsm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wdsm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wdsm_pkg::cmd_t                  cmd_i,
  output wdsm_pkg::sts_t                  sts_o,
  output logic [wdsm_pkg::OUT_W-1:0]      out_data_o
);
  import wdsm_pkg::*;

  localparam int ACC_W = 58;
  localparam int SW    = FRAC_BITS + 1;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // Configuration
  logic signed [WEIGHT_W-1:0] wc_q, ws_q, wm_q;
  logic [LIMIT_W-1:0]         climit_q, jlimit_q;
  logic [WEIGHT_W-1:0]        gain_q;
  logic signed [31:0]         thr_q;
  logic [UNIT_W-1:0]          margin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q     <= WEIGHT_W'(1) << FRAC_BITS;
      ws_q     <= WEIGHT_W'(1) << FRAC_BITS;
      wm_q     <= WEIGHT_W'(1) << FRAC_BITS;
      climit_q <= LIMIT_W'(1) << FRAC_BITS;
      gain_q   <= WEIGHT_W'(1) << FRAC_BITS;
      jlimit_q <= LIMIT_W'(1) << FRAC_BITS;
      thr_q    <= 32'(1) << FRAC_BITS;
      margin_q <= UNIT_W'(1) << (FRAC_BITS - 1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_W_COHERENCE:   wc_q     <= cfg_data_i[WEIGHT_W-1:0];
        REG_W_SPECTRAL:    ws_q     <= cfg_data_i[WEIGHT_W-1:0];
        REG_W_MEMORY:      wm_q     <= cfg_data_i[WEIGHT_W-1:0];
        REG_CHANGE_LIMIT:  climit_q <= cfg_data_i[LIMIT_W-1:0];
        REG_COST_GAIN:     gain_q   <= cfg_data_i[WEIGHT_W-1:0];
        REG_JOINT_LIMIT:   jlimit_q <= cfg_data_i[LIMIT_W-1:0];
        REG_FC_THRESHOLD:  thr_q    <= cfg_data_i;
        REG_STEADY_MARGIN: margin_q <= cfg_data_i[UNIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured metrics
  logic signed [31:0] coh_q, spe_q, mem_q, anc_q, leak_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      coh_q  <= in_data_i[31:0];
      spe_q  <= in_data_i[63:32];
      mem_q  <= in_data_i[95:64];
      anc_q  <= in_data_i[127:96];
      leak_q <= in_data_i[159:128];
    end
  end

  // Shared multiplier, product registered
  logic signed [32:0]      mul_a, mul_b;
  logic signed [65:0]      prod_full;
  logic signed [63:0]      prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [31:0]             mag_q;

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_W0: begin
        mul_a = 33'(wc_q);
        mul_b = 33'(coh_q);
      end
      MUL_W1: begin
        mul_a = 33'(ws_q);
        mul_b = 33'(spe_q);
      end
      MUL_W2: begin
        mul_a = 33'(wm_q);
        mul_b = 33'(mem_q);
      end
      MUL_GAIN: begin
        mul_a = {9'b0, gain_q};
        mul_b = {1'b0, mag_q};
      end
      MUL_LEAK: begin
        mul_a = 33'(leak_q);
        mul_b = {1'b0, mag_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_full = mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_full[63:0];
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + $signed(prod_q[ACC_W-1:0]);
    end
  end

  // Level, change and magnitudes
  logic signed [31:0]      level_q, change_q, prior_q;
  logic                    prior_valid_q;
  logic signed [ACC_W-1:0] lvl_shift;
  logic signed [32:0]      diff;
  logic [32:0]             mag_neg, anc_neg;
  logic [31:0]             mag_d, anc_mag;
  logic [32:0]             joint_q;

  always_comb begin
    lvl_shift = acc_q >>> FRAC_BITS;
    diff      = 33'(level_q) - 33'(prior_q);
    mag_neg   = -{change_q[31], change_q};
    anc_neg   = -{anc_q[31], anc_q};
    mag_d     = change_q[31] ? mag_neg[31:0] : change_q;
    anc_mag   = anc_q[31] ? anc_neg[31:0] : anc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q       <= '0;
      prior_valid_q <= 1'b0;
    end else if (cmd_i.change_en) begin
      prior_q       <= level_q;
      prior_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.level_en) begin
      level_q <= sat32(64'(lvl_shift));
    end
    if (cmd_i.change_en) begin
      change_q <= prior_valid_q ? sat32(64'(diff)) : '0;
    end
    if (cmd_i.mag_en) begin
      mag_q <= mag_d;
    end
    if (cmd_i.joint_en) begin
      joint_q <= {1'b0, mag_q} + {1'b0, anc_mag};
    end
  end

  // Cost and forecast from the shared product
  logic signed [63:0] prod_sh;
  logic [31:0]        cost_q;
  logic signed [31:0] fc_q;

  assign prod_sh = prod_q >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cost_en) begin
      cost_q <= (|prod_sh[63:32]) ? 32'hffffffff : prod_sh[31:0];
    end
    if (cmd_i.fc_en) begin
      fc_q <= sat32(prod_sh);
    end
  end

  // Divider for steadiness and agreement
  logic          div_busy;
  logic [SW-1:0] div_res;
  logic [SW-1:0] steady_q, agree_q;

  wdsm_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (cmd_i.div_sel ? joint_q : {1'b0, mag_q}),
    .lim_i   (cmd_i.div_sel ? jlimit_q : climit_q),
    .busy_o  (div_busy),
    .res_o   (div_res)
  );

  assign sts_o.div_busy = div_busy;

  always_ff @(posedge clk_i) begin
    if (cmd_i.steady_en) begin
      steady_q <= div_res;
    end
    if (cmd_i.agree_en) begin
      agree_q <= div_res;
    end
  end

  // Result register
  logic       cut, hold, backoff;
  logic [OUT_W-1:0] out_q;

  always_comb begin
    cut     = fc_q > thr_q;
    hold    = 32'(steady_q) < 32'(margin_q);
    backoff = mag_q > {1'b0, climit_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {3'b000, backoff, hold, cut, fc_q, UNIT_W'(agree_q), cost_q,
                UNIT_W'(steady_q), change_q};
    end
  end

  assign out_data_o = out_q;

endmodule

/* src/wdsm_ctrl.sv */
// Controller: sequences one transaction through the datapath and owns both handshakes.
module wdsm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  wdsm_pkg::sts_t sts_i,
  output wdsm_pkg::cmd_t cmd_o
);
  import wdsm_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MW0    = 4'd1;
  localparam logic [3:0] S_MW1    = 4'd2;
  localparam logic [3:0] S_MW2    = 4'd3;
  localparam logic [3:0] S_ACC    = 4'd4;
  localparam logic [3:0] S_LEVEL  = 4'd5;
  localparam logic [3:0] S_CHANGE = 4'd6;
  localparam logic [3:0] S_MAG    = 4'd7;
  localparam logic [3:0] S_COST   = 4'd8;
  localparam logic [3:0] S_FCM    = 4'd9;
  localparam logic [3:0] S_FCS    = 4'd10;
  localparam logic [3:0] S_DIV0   = 4'd11;
  localparam logic [3:0] S_DIV1S  = 4'd12;
  localparam logic [3:0] S_DIV1   = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_MW0;
        end
      end
      S_MW0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_W0;
        cmd_o.acc_clr = 1'b1;
        state_d       = S_MW1;
      end
      S_MW1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_W1;
        cmd_o.acc_en  = 1'b1;
        state_d       = S_MW2;
      end
      S_MW2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_W2;
        cmd_o.acc_en  = 1'b1;
        state_d       = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d      = S_LEVEL;
      end
      S_LEVEL: begin
        cmd_o.level_en = 1'b1;
        state_d        = S_CHANGE;
      end
      S_CHANGE: begin
        cmd_o.change_en = 1'b1;
        state_d         = S_MAG;
      end
      S_MAG: begin
        cmd_o.mag_en = 1'b1;
        state_d      = S_COST;
      end
      S_COST: begin
        // Start the steadiness division alongside the cost product
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_GAIN;
        cmd_o.joint_en  = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = S_FCM;
      end
      S_FCM: begin
        cmd_o.cost_en = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LEAK;
        state_d       = S_FCS;
      end
      S_FCS: begin
        cmd_o.fc_en = 1'b1;
        state_d     = S_DIV0;
      end
      S_DIV0: begin
        if (!sts_i.div_busy) begin
          cmd_o.steady_en = 1'b1;
          state_d         = S_DIV1S;
        end
      end
      S_DIV1S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
        state_d         = S_DIV1;
      end
      S_DIV1: begin
        cmd_o.div_sel = 1'b1;
        if (!sts_i.div_busy) begin
          cmd_o.agree_en = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input accepted twice in a row");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_o)
    else $error("loaded result not presented");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy)
    else $error("divider started while busy");

endmodule

/* src/weighted_drift_stability_monitor.sv */
// Top level of the weighted drift stability monitor: controller plus datapath.
//
//  channel  | direction | handshake                      | payload
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | s_axis_tdata, five Q16.16 metrics
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | m_axis_tdata, change, scores, flags
//  cfg      | in        | cfg_we_i (no wait)             | cfg_idx_i, cfg_data_i
//
// A transaction runs through the controller's steps in turn and is paced by
// the serial divider, which produces one quotient bit a cycle for two divisions in turn.
// Reset returns the registers to their defaults and forgets the previous level.
// A finished result waits in the output register; the next transaction is taken
// meanwhile and stalls only in its last step if the result has not yet been taken.
module weighted_drift_stability_monitor #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // coherence_shift, spectral_shift, memory_change, anchor_shift, leak_level
  input  logic [wdsm_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // step_change, steadiness, change_cost, anchor_agreement, forecast_score,
  // cut_heavy_work, hold_replication, raise_backoff, zero fill
  output logic [wdsm_pkg::OUT_W-1:0]      m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [wdsm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wdsm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wdsm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wdsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wdsm_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata)
  );

endmodule

/* tb/testbench.sv */
// Self-checking testbench of the weighted drift stability monitor: predicts every result.
`timescale 1ns / 1ps

module testbench;
  import wdsm_pkg::*;

  localparam int              FRAC        = 16;
  localparam longint unsigned ONE_Q       = 64'd1 << FRAC;
  localparam longint          S32_MAX     = 64'sd2147483647;
  localparam longint          S32_MIN     = -64'sd2147483648;
  localparam int              NUM_REGS    = 8;
  localparam int              PHASES      = 8;
  localparam int              PHASE_ITEMS = 140;
  localparam int              STALL_ITEMS = 16;
  localparam int              HOLD_OFF    = 300;
  localparam int              QUIET_LIMIT = 4000;
  localparam int              TAIL_CYCLES = 100;

  // First member sits in the highest bits, so the last member is the lowest field.
  typedef struct packed {
    logic signed [31:0] leak_level;
    logic signed [31:0] anchor_shift;
    logic signed [31:0] memory_change;
    logic signed [31:0] spectral_shift;
    logic signed [31:0] coherence_shift;
  } metrics_t;

  typedef struct packed {
    logic [2:0]         fill;
    logic               raise_backoff;
    logic               hold_replication;
    logic               cut_heavy_work;
    logic signed [31:0] forecast_score;
    logic [16:0]        anchor_agreement;
    logic [31:0]        change_cost;
    logic [16:0]        steadiness;
    logic signed [31:0] step_change;
  } drift_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Register copies held by the predictor, at reset values
  logic signed [WEIGHT_W-1:0] w_coh_r       = 24'h01_0000;
  logic signed [WEIGHT_W-1:0] w_spe_r       = 24'h01_0000;
  logic signed [WEIGHT_W-1:0] w_mem_r       = 24'h01_0000;
  logic [LIMIT_W-1:0]         chg_limit_r   = 31'h0001_0000;
  logic [WEIGHT_W-1:0]        gain_r        = 24'h01_0000;
  logic [LIMIT_W-1:0]         joint_limit_r = 31'h0001_0000;
  logic signed [31:0]         fc_thr_r      = 32'h0001_0000;
  logic [UNIT_W-1:0]          margin_r      = 17'h0_8000;
  logic signed [31:0]         prior_level   = '0;
  logic                       prior_valid   = 1'b0;

  drift_result_t         pending_results[$];
  logic [CFG_DATA_W-1:0] cfg_plan [NUM_REGS];

  int   errors           = 0;
  int   items_accepted   = 0;
  int   results_checked  = 0;
  int   settings_applied = 0;
  int   src_idle_pct     = 36;
  int   sink_idle_pct    = 66;
  int   quiet_cycles     = 0;
  logic hold_off_req     = 1'b0;

  weighted_drift_stability_monitor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic longint sat32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // clamp(1 - num / lim, 0, 1); a zero limit divides as 1.0
  function automatic longint unsigned unit_headroom(longint unsigned num,
                                                    longint unsigned lim);
    longint unsigned q;
    if (lim == 0) lim = ONE_Q;
    q = (num << FRAC) / lim;
    return (q >= ONE_Q) ? 64'd0 : ONE_Q - q;
  endfunction

  // Advances the stored level, so call once per accepted transaction
  function automatic drift_result_t predict_drift(metrics_t m);
    longint          sum, level, change, anc, leak, mag_s, fc;
    longint unsigned mag, anc_mag, cost, steady, agree;
    drift_result_t   r;
    sum = longint'(w_coh_r) * longint'($signed(m.coherence_shift))
        + longint'(w_spe_r) * longint'($signed(m.spectral_shift))
        + longint'(w_mem_r) * longint'($signed(m.memory_change));
    level  = sat32(sum >>> FRAC);
    change = prior_valid ? sat32(level - longint'(prior_level)) : 64'sd0;
    anc    = longint'($signed(m.anchor_shift));
    leak   = longint'($signed(m.leak_level));
    if (change < 0) mag = -change; else mag = change;
    if (anc < 0) anc_mag = -anc; else anc_mag = anc;
    steady = unit_headroom(mag, chg_limit_r);
    cost   = (gain_r * mag) >> FRAC;
    if (cost > 64'hFFFF_FFFF) cost = 64'hFFFF_FFFF;
    agree  = unit_headroom(mag + anc_mag, joint_limit_r);
    mag_s  = mag;
    fc     = sat32((mag_s * leak) >>> FRAC);
    r                  = '0;
    r.step_change      = change[31:0];
    r.steadiness       = steady[16:0];
    r.change_cost      = cost[31:0];
    r.anchor_agreement = agree[16:0];
    r.forecast_score   = fc[31:0];
    r.cut_heavy_work   = (fc > longint'(fc_thr_r));
    r.hold_replication = (steady < margin_r);
    r.raise_backoff    = (mag > chg_limit_r);
    prior_level = level[31:0];
    prior_valid = 1'b1;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Check first, then predict, so both sides of one edge use pre-edge values
  always @(posedge clk_i) begin : scoreboard
    drift_result_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        $display("%0t ns: result %h arrived with no item outstanding", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("step_change", want.step_change, got.step_change);
        check_field("steadiness", want.steadiness, got.steadiness);
        check_field("change_cost", want.change_cost, got.change_cost);
        check_field("anchor_agreement", want.anchor_agreement, got.anchor_agreement);
        check_field("forecast_score", want.forecast_score, got.forecast_score);
        check_field("cut_heavy_work", want.cut_heavy_work, got.cut_heavy_work);
        check_field("hold_replication", want.hold_replication, got.hold_replication);
        check_field("raise_backoff", want.raise_backoff, got.raise_backoff);
      end
      results_checked++;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      pending_results.push_back(predict_drift(metrics_t'(s_axis_tdata)));
      items_accepted++;
    end
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_W_COHERENCE:   w_coh_r       = cfg_data_i[WEIGHT_W-1:0];
        REG_W_SPECTRAL:    w_spe_r       = cfg_data_i[WEIGHT_W-1:0];
        REG_W_MEMORY:      w_mem_r       = cfg_data_i[WEIGHT_W-1:0];
        REG_CHANGE_LIMIT:  chg_limit_r   = cfg_data_i[LIMIT_W-1:0];
        REG_COST_GAIN:     gain_r        = cfg_data_i[WEIGHT_W-1:0];
        REG_JOINT_LIMIT:   joint_limit_r = cfg_data_i[LIMIT_W-1:0];
        REG_FC_THRESHOLD:  fc_thr_r      = cfg_data_i;
        REG_STEADY_MARGIN: margin_r      = cfg_data_i[UNIT_W-1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("weighted_drift_stability_monitor regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random back-pressure, or a long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        stall_left   = HOLD_OFF;
        hold_off_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Leaves tvalid high after the transaction so that a back-to-back item needs no toggle
  task automatic send_metrics(input metrics_t m);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= m;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic apply_config;
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(i);
      cfg_data_i <= cfg_plan[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  task automatic program_regs(input logic [31:0] w_coh, w_spe, w_mem, chg_lim, gain,
                              joint_lim, thr, margin);
    drain;
    cfg_plan[REG_W_COHERENCE]   = w_coh;
    cfg_plan[REG_W_SPECTRAL]    = w_spe;
    cfg_plan[REG_W_MEMORY]      = w_mem;
    cfg_plan[REG_CHANGE_LIMIT]  = chg_lim;
    cfg_plan[REG_COST_GAIN]     = gain;
    cfg_plan[REG_JOINT_LIMIT]   = joint_lim;
    cfg_plan[REG_FC_THRESHOLD]  = thr;
    cfg_plan[REG_STEADY_MARGIN] = margin;
    apply_config;
  endtask

  function automatic metrics_t epoch_metrics(input logic [31:0] coh, spe, mem, anc, leak);
    metrics_t m;
    m.coherence_shift = coh;
    m.spectral_shift  = spe;
    m.memory_change   = mem;
    m.anchor_shift    = anc;
    m.leak_level      = leak;
    return m;
  endfunction

  function automatic logic [31:0] signed_span(int unsigned span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  function automatic logic [31:0] corner_value;
    case ($urandom_range(4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0001_0000;
    endcase
  endfunction

  // Mostly small metrics, so that changes land near the limits and thresholds
  function automatic metrics_t random_metrics;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60)
      return epoch_metrics(signed_span(8 << FRAC), signed_span(8 << FRAC),
                           signed_span(8 << FRAC), signed_span(8 << FRAC),
                           signed_span(8 << FRAC));
    if (pick < 85)
      return epoch_metrics($urandom, $urandom, $urandom, $urandom, $urandom);
    return epoch_metrics(corner_value(), corner_value(), corner_value(), corner_value(),
                         corner_value());
  endfunction

  // Raw 32-bit values now and then, to drive the bits above each register's width
  function automatic logic [31:0] random_reg(logic [CFG_IDX_W-1:0] idx);
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 2) return $urandom;
    case (idx)
      REG_W_COHERENCE, REG_W_SPECTRAL, REG_W_MEMORY: begin
        if (pick == 2) return 32'h007F_FFFF;
        if (pick == 3) return 32'h0080_0000;
        return signed_span(2 << FRAC);
      end
      REG_CHANGE_LIMIT, REG_JOINT_LIMIT: begin
        if (pick == 2) return 32'h0000_0000;
        if (pick == 3) return 32'h7FFF_FFFF;
        return $urandom_range(1, 32 << FRAC);
      end
      REG_COST_GAIN: begin
        if (pick == 2) return 32'h0000_0000;
        if (pick == 3) return 32'h00FF_FFFF;
        return $urandom_range(0, 4 << FRAC);
      end
      REG_FC_THRESHOLD: begin
        if (pick == 2) return 32'h8000_0000;
        if (pick == 3) return 32'h7FFF_FFFF;
        return signed_span(64 << FRAC);
      end
      default: begin
        if (pick == 2) return 32'h0000_0000;
        if (pick == 3) return 32'h0001_0000;
        return $urandom_range(0, 1 << FRAC);
      end
    endcase
  endfunction

  task automatic test_first_item_and_defaults;
    send_metrics(epoch_metrics(32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    // change of exactly the limit: steadiness zero, no backoff
    send_metrics(epoch_metrics(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000));
    send_metrics(epoch_metrics(32'h0001_8000, 32'h0, 32'h0, 32'h0000_4000, 32'h0002_0000));
    send_metrics(epoch_metrics(32'h0001_8000, 32'h0, 32'h0, 32'h0000_4000, 32'h0002_0000));
    send_metrics(epoch_metrics(32'hFFFD_0000, 32'h0000_8000, 32'hFFFF_8000, 32'hFFFF_0000,
                               32'hFFFF_0000));
    send_metrics(epoch_metrics(32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF));
    send_metrics(epoch_metrics(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF));
    send_metrics(epoch_metrics(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000));
  endtask

  task automatic test_zero_limits;
    program_regs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0,
                 32'hFFFF_FFFF, 32'h0001_0000);
    send_metrics(epoch_metrics(32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    // zero change against a zero limit: no backoff
    send_metrics(epoch_metrics(32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    send_metrics(epoch_metrics(32'h1, 32'h0, 32'h0, 32'h0, 32'h0001_0000));
    send_metrics(epoch_metrics(32'h0000_8001, 32'h0, 32'h0, 32'h0000_8000, 32'hFFFF_0000));
  endtask

  task automatic test_saturation;
    program_regs(32'h007F_FFFF, 32'h0080_0000, 32'h007F_FFFF, 32'h7FFF_FFFF, 32'h00FF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    send_metrics(epoch_metrics(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'h7FFF_FFFF));
    send_metrics(epoch_metrics(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h8000_0000));
    send_metrics(epoch_metrics(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'h7FFF_FFFF));
    send_metrics(epoch_metrics(32'h1, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
    send_metrics(epoch_metrics(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000));
  endtask

  task automatic test_margin_above_one;
    // the margin keeps 17 bits, so the hold flag is always raised
    program_regs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                 32'h0001_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_metrics(epoch_metrics(32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    send_metrics(epoch_metrics(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000));
  endtask

  task automatic test_random_traffic;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 3) begin
        src_idle_pct  = 36;
        sink_idle_pct = 66;
      end else if (phase < 6) begin
        src_idle_pct  = 66;
        sink_idle_pct = 36;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      drain;
      for (int i = 0; i < NUM_REGS; i++) cfg_plan[i] = random_reg(CFG_IDX_W'(i));
      apply_config;
      repeat (PHASE_ITEMS) send_metrics(random_metrics());
    end
  endtask

  // Hold the result side off while items keep coming, so the input stalls
  task automatic test_output_stall;
    program_regs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0004_0000, 32'h0002_0000,
                 32'h0008_0000, 32'h0001_0000, 32'h0000_8000);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_off_req  = 1'b1;
    repeat (STALL_ITEMS) send_metrics(random_metrics());
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_item_and_defaults;
    test_zero_limits;
    test_saturation;
    test_margin_above_one;
    test_random_traffic;
    test_output_stall;

    drain;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Checked %0d results from %0d metric transactions over %0d register settings,",
             results_checked, items_accepted, settings_applied);
    $display("with zero limits, saturating weights, three idle mixes and a long output stall.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("weighted_drift_stability_monitor regression: pass");
    end else begin
      $display("weighted_drift_stability_monitor regression: fail");
    end
    $finish;
  end

endmodule
